// ----- src/spsp_pkg.sv -----
// Shared types and widths for the sprite projection setup block.
// Depends on nothing; every other file but spsp_div imports it.
package spsp_pkg;

    // Default tile size in world units
    localparam int TILE_UNITS_DEF = 64;
    // Widths sized for the largest tile size (256 units)
    localparam int TILE_W  = 9;
    localparam int NX_W    = 18;            // relative position, signed
    localparam int PR_W    = 34;            // position * vector product
    localparam int DP_W    = 32;            // vector * vector product
    localparam int DET_W   = 33;            // determinant
    localparam int TY_W    = 35;            // transformed x / y numerators
    localparam int TM_W    = 34;            // |tyn|
    localparam int SUM_W   = 36;            // tyn + txn
    localparam int DNUM_W  = TM_W + 22;     // depth dividend
    localparam int DDEN_W  = 32 + TILE_W;   // depth divisor
    localparam int CNUM_W  = SUM_W + 12;    // center dividend
    localparam int CDEN_W  = TM_W;          // center divisor
    localparam int DEPTH_QW  = 16;
    localparam int CENTER_QW = 17;
    localparam int SIZE_QW   = 13;

    // Register indexes
    localparam logic [2:0] REG_CAM_POS_X = 3'd0;
    localparam logic [2:0] REG_CAM_POS_Y = 3'd1;
    localparam logic [2:0] REG_DIR_X     = 3'd2;
    localparam logic [2:0] REG_DIR_Y     = 3'd3;
    localparam logic [2:0] REG_PLANE_X   = 3'd4;
    localparam logic [2:0] REG_PLANE_Y   = 3'd5;
    localparam logic [2:0] REG_SCREEN_W  = 3'd6;
    localparam logic [2:0] REG_SCREEN_H  = 3'd7;

    typedef struct packed {
        logic [7:0] sprite_tile_x;
        logic [7:0] sprite_tile_y;
        logic       last_sprite;
    } t_item;

    typedef struct packed {
        logic               visible;
        logic [15:0]        depth;
        logic signed [15:0] center_column;
        logic [12:0]        size_px;
        logic [12:0]        start_column;
        logic [12:0]        end_column;
        logic [12:0]        start_row;
        logic [12:0]        end_row;
        logic               frame_done;
    } t_result;

    typedef struct packed {
        logic [15:0] cam_pos_x;
        logic [15:0] cam_pos_y;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] plane_x;
        logic [15:0] plane_y;
        logic [12:0] screen_width;
        logic [12:0] screen_height;
    } t_cfg;

    // Classified sprite handed from front to back
    typedef struct packed {
        logic              frame_done;
        logic              ok;         // det nonzero, sprite in front
        logic              neg;        // center quotient is negative
        logic [DNUM_W-1:0] dnum;
        logic [DDEN_W-1:0] dden;
        logic [CNUM_W-1:0] cnum;
        logic [CDEN_W-1:0] cden;
    } t_work;

endpackage

// ----- src/sprite_projection_setup.sv -----
// Top level of the billboard sprite projection setup block.
// Uses spsp_pkg, spsp_front, spsp_queue, spsp_back.
//
//   channel   ports                               handshake
//   item in   start, busy, i_item                 taken when start & !busy
//   result    o_result_valid, o_result            one-cycle strobe, no stall
//   config    i_cfg_we, i_cfg_index, i_cfg_data   write when i_cfg_we
//
// One sprite per cycle while busy is low. A result passes the four-stage
// front end, the queue, then the chained depth (16 bit) and size (13 bit)
// dividers, one quotient bit per stage.
// Reset clears valid bits and loads the register defaults; the results
// cannot be held off, and busy rises only if the front queue fills.
module sprite_projection_setup
    import spsp_pkg::*;
#(
    parameter int TILE_UNITS = TILE_UNITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_item       i_item,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    output logic        o_result_valid,
    output t_result     o_result
);
    t_cfg  r_cfg;
    logic  w_take, w_fv, w_qv, w_full;
    t_work w_fwork, w_qwork;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cam_pos_x     <= 16'd0;
            r_cfg.cam_pos_y     <= 16'd0;
            r_cfg.dir_x         <= 16'd16384;
            r_cfg.dir_y         <= 16'd0;
            r_cfg.plane_x       <= 16'd0;
            r_cfg.plane_y       <= 16'd10813;
            r_cfg.screen_width  <= 13'd640;
            r_cfg.screen_height <= 13'd480;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CAM_POS_X: r_cfg.cam_pos_x     <= i_cfg_data;
                REG_CAM_POS_Y: r_cfg.cam_pos_y     <= i_cfg_data;
                REG_DIR_X:     r_cfg.dir_x         <= i_cfg_data;
                REG_DIR_Y:     r_cfg.dir_y         <= i_cfg_data;
                REG_PLANE_X:   r_cfg.plane_x       <= i_cfg_data;
                REG_PLANE_Y:   r_cfg.plane_y       <= i_cfg_data;
                REG_SCREEN_W:  r_cfg.screen_width  <= i_cfg_data[12:0];
                REG_SCREEN_H:  r_cfg.screen_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    assign busy   = w_full;
    assign w_take = start && !busy;

    spsp_front #(.TILE_UNITS(TILE_UNITS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_take(w_take), .i_item(i_item),
        .i_cfg(r_cfg), .o_valid(w_fv), .o_work(w_fwork)
    );

    spsp_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_fv), .i_work(w_fwork),
        .i_pop(1'b1), .o_valid(w_qv), .o_full(w_full), .o_work(w_qwork)
    );

    spsp_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(w_qv), .i_work(w_qwork),
        .i_screen_width(r_cfg.screen_width),
        .i_screen_height(r_cfg.screen_height),
        .o_valid(o_result_valid), .o_result(o_result)
    );

    // A hidden sprite carries no geometry
    a_hidden_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_result.visible) |->
            (o_result.depth == '0 && o_result.size_px == '0
             && o_result.end_column == '0))
        else $error("hidden sprite with nonzero fields");

    // A visible sprite has nonzero depth and spans within the screen
    a_visible_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.visible) |->
            (o_result.depth != '0 && o_result.end_column <= r_cfg.screen_width
             && o_result.start_row <= o_result.end_row))
        else $error("visible sprite out of bounds");

    // The queue never overflows since the back end drains every cycle
    a_no_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fv |-> !w_full)
        else $error("push into full queue");
endmodule

// ----- src/spsp_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, saturating.
// Generic; no package use.
module spsp_div #(
    parameter int NW = 16,
    parameter int DW = 16,
    parameter int QW = 8
) (
    input  logic          i_clk,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);
    localparam int XW = ((NW > DW + QW) ? NW : DW + QW) + 1;

    logic [XW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_quo [QW+1];
    logic          r_sat [QW+1];

    // Entry stage: overflow check against den * 2^QW
    always_ff @(posedge i_clk) begin
        r_rem[0] <= XW'(i_num);
        r_den[0] <= i_den;
        r_quo[0] <= '0;
        r_sat[0] <= XW'(i_num) >= (XW'(i_den) << QW);
    end

    // One bit per stage, MSB first
    for (genvar k = 1; k <= QW; k++) begin : g_stage
        localparam int B = QW - k;
        logic [XW-1:0] w_sh;
        logic          w_ge;
        assign w_sh = XW'(r_den[k-1]) << B;
        assign w_ge = r_rem[k-1] >= w_sh;
        always_ff @(posedge i_clk) begin
            r_quo[k] <= r_quo[k-1] | (QW'(w_ge) << B);
            r_sat[k] <= r_sat[k-1];
        end
        if (k < QW) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_rem[k] <= w_ge ? r_rem[k-1] - w_sh : r_rem[k-1];
                r_den[k] <= r_den[k-1];
            end
        end
    end

    assign o_quo = r_sat[QW] ? '1 : r_quo[QW];
endmodule

// ----- src/spsp_front.sv -----
// Front end: relative position, camera transform and classification.
// Uses spsp_pkg; four register stages.
module spsp_front
    import spsp_pkg::*;
#(
    parameter int TILE_UNITS = TILE_UNITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_take,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output logic  o_valid,
    output t_work o_work
);
    logic [3:0] r_v;

    logic signed [NX_W-1:0]  r_nx, r_ny;
    logic                    r_fd1, r_fd2, r_fd3;
    logic signed [PR_W-1:0]  r_pxny, r_pynx, r_dynx, r_dxny;
    logic signed [DP_W-1:0]  r_pxdy, r_dxpy;
    logic signed [TY_W-1:0]  r_tyn;
    logic signed [DET_W-1:0] r_det;
    logic signed [SUM_W-1:0] r_sum;
    t_work                   r_work;

    logic [TY_W-1:0]  w_tyn_abs;
    logic [DET_W-1:0] w_det_abs;
    logic [SUM_W-1:0] w_sum_abs;
    logic [11:0]      w_half;

    // Valid pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= {r_v[2:0], i_take};
        end
    end

    // Stage 1: tile center minus player, wraps into the signed range
    always_ff @(posedge i_clk) begin
        r_nx  <= NX_W'(i_item.sprite_tile_x) * NX_W'(TILE_UNITS)
               + NX_W'(TILE_UNITS / 2) - NX_W'(i_cfg.cam_pos_x);
        r_ny  <= NX_W'(i_item.sprite_tile_y) * NX_W'(TILE_UNITS)
               + NX_W'(TILE_UNITS / 2) - NX_W'(i_cfg.cam_pos_y);
        r_fd1 <= i_item.last_sprite;
    end

    // Stage 2: products
    always_ff @(posedge i_clk) begin
        r_pxny <= PR_W'($signed(i_cfg.plane_x)) * PR_W'(r_ny);
        r_pynx <= PR_W'($signed(i_cfg.plane_y)) * PR_W'(r_nx);
        r_dynx <= PR_W'($signed(i_cfg.dir_y)) * PR_W'(r_nx);
        r_dxny <= PR_W'($signed(i_cfg.dir_x)) * PR_W'(r_ny);
        r_pxdy <= DP_W'($signed(i_cfg.plane_x)) * DP_W'($signed(i_cfg.dir_y));
        r_dxpy <= DP_W'($signed(i_cfg.dir_x)) * DP_W'($signed(i_cfg.plane_y));
        r_fd2  <= r_fd1;
    end

    // Stage 3: sums
    always_ff @(posedge i_clk) begin
        r_tyn <= TY_W'(r_pxny) - TY_W'(r_pynx);
        r_det <= DET_W'(r_pxdy) - DET_W'(r_dxpy);
        r_sum <= SUM_W'(r_pxny) - SUM_W'(r_pynx) + SUM_W'(r_dynx) - SUM_W'(r_dxny);
        r_fd3 <= r_fd2;
    end

    // Stage 4: magnitudes, divider operands, classification
    always_comb begin
        w_tyn_abs = r_tyn[TY_W-1] ? TY_W'(-r_tyn) : TY_W'(r_tyn);
        w_det_abs = r_det[DET_W-1] ? DET_W'(-r_det) : DET_W'(r_det);
        w_sum_abs = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_half    = i_cfg.screen_width[12:1];
    end

    always_ff @(posedge i_clk) begin
        r_work.frame_done <= r_fd3;
        r_work.ok   <= (r_det != '0) && (r_tyn != '0)
                    && (r_tyn[TY_W-1] == r_det[DET_W-1]);
        r_work.neg  <= r_sum[SUM_W-1] ^ r_tyn[TY_W-1];
        r_work.dnum <= {w_tyn_abs[TM_W-1:0], 22'b0};
        r_work.dden <= DDEN_W'(w_det_abs[31:0]) * DDEN_W'(TILE_UNITS);
        r_work.cnum <= CNUM_W'(w_half) * CNUM_W'(w_sum_abs);
        r_work.cden <= w_tyn_abs[TM_W-1:0];
    end

    assign o_valid = r_v[3];
    assign o_work  = r_work;
endmodule

// ----- src/spsp_queue.sv -----
// Two-entry queue between front and back.
// Uses spsp_pkg for the item type.
module spsp_queue
    import spsp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_work i_work,
    input  logic  i_pop,
    output logic  o_valid,
    output logic  o_full,
    output t_work o_work
);
    t_work      r_mem [2];
    logic       r_wr, r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop = i_pop && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_work;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (w_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    assign o_valid = r_cnt != 2'd0;
    assign o_full  = r_cnt == 2'd2;
    assign o_work  = r_mem[r_rd];
endmodule

// ----- src/spsp_back.sv -----
// Back end: depth, center and size dividers, bounds and result register.
// Uses spsp_pkg and spsp_div.
module spsp_back
    import spsp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_work       i_work,
    input  logic [12:0] i_screen_width,
    input  logic [12:0] i_screen_height,
    output logic        o_valid,
    output t_result     o_result
);
    typedef struct packed {
        logic valid;
        logic fd;
        logic ok;
        logic neg;
    } t_side_a;

    typedef struct packed {
        logic               valid;
        logic               fd;
        logic               vis;
        logic               neg;
        logic [15:0]        depth;
        logic signed [15:0] center;
    } t_side_b;

    localparam int A_LEN = DEPTH_QW + 1;
    localparam int B_LEN = SIZE_QW + 1;

    t_side_a r_a [A_LEN];
    t_side_b r_b0;
    t_side_b r_b [B_LEN];
    t_side_b w_b_in;
    logic    r_out_v;
    t_result r_res;
    t_result w_res;

    logic [DEPTH_QW-1:0]  w_dq;
    logic [CENTER_QW-1:0] w_cq;
    logic [SIZE_QW-1:0]   w_sq;

    logic signed [17:0] w_c, w_hs, w_w, w_h, w_hh;
    logic signed [17:0] w_sc, w_ec, w_sr, w_er;

    spsp_div #(.NW(DNUM_W), .DW(DDEN_W), .QW(DEPTH_QW)) u_depth_div (
        .i_clk(i_clk), .i_num(i_work.dnum), .i_den(i_work.dden), .o_quo(w_dq)
    );

    spsp_div #(.NW(CNUM_W), .DW(CDEN_W), .QW(CENTER_QW)) u_center_div (
        .i_clk(i_clk), .i_num(i_work.cnum), .i_den(i_work.cden), .o_quo(w_cq)
    );

    spsp_div #(.NW(21), .DW(16), .QW(SIZE_QW)) u_size_div (
        .i_clk(i_clk), .i_num({i_screen_width, 8'b0}), .i_den(r_b0.depth),
        .o_quo(w_sq)
    );

    // Side line alongside the depth divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < A_LEN; k++) r_a[k].valid <= 1'b0;
        end else begin
            r_a[0].valid <= i_valid;
            for (int k = 1; k < A_LEN; k++) r_a[k].valid <= r_a[k-1].valid;
        end
        r_a[0].fd  <= i_work.frame_done;
        r_a[0].ok  <= i_work.ok;
        r_a[0].neg <= i_work.neg;
        for (int k = 1; k < A_LEN; k++) begin
            r_a[k].fd  <= r_a[k-1].fd;
            r_a[k].ok  <= r_a[k-1].ok;
            r_a[k].neg <= r_a[k-1].neg;
        end
    end

    // Depth result stage; lines up with the center divider output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0.valid <= 1'b0;
        end else begin
            r_b0.valid <= r_a[A_LEN-1].valid;
        end
        r_b0.fd     <= r_a[A_LEN-1].fd;
        r_b0.neg    <= r_a[A_LEN-1].neg;
        r_b0.vis    <= r_a[A_LEN-1].ok && (w_dq != '0);
        r_b0.depth  <= w_dq;
        r_b0.center <= '0;
    end

    // Saturate the signed center into 16 bits
    always_comb begin
        w_b_in = r_b0;
        if (r_b0.neg) begin
            w_b_in.center = (w_cq > CENTER_QW'(32768)) ? 16'sh8000
                          : 16'(-$signed({1'b0, w_cq}));
        end else begin
            w_b_in.center = (w_cq > CENTER_QW'(32767)) ? 16'sh7fff
                          : 16'(w_cq);
        end
    end

    // Side line alongside the size divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < B_LEN; k++) r_b[k].valid <= 1'b0;
        end else begin
            r_b[0].valid <= w_b_in.valid;
            for (int k = 1; k < B_LEN; k++) r_b[k].valid <= r_b[k-1].valid;
        end
        r_b[0].fd     <= w_b_in.fd;
        r_b[0].vis    <= w_b_in.vis;
        r_b[0].neg    <= w_b_in.neg;
        r_b[0].depth  <= w_b_in.depth;
        r_b[0].center <= w_b_in.center;
        for (int k = 1; k < B_LEN; k++) begin
            r_b[k].fd     <= r_b[k-1].fd;
            r_b[k].vis    <= r_b[k-1].vis;
            r_b[k].neg    <= r_b[k-1].neg;
            r_b[k].depth  <= r_b[k-1].depth;
            r_b[k].center <= r_b[k-1].center;
        end
    end

    function automatic logic [12:0] clip(input logic signed [17:0] v,
                                         input logic signed [17:0] hi);
        if (v < 18'sd0) return 13'd0;
        if (v > hi)     return hi[12:0];
        return v[12:0];
    endfunction

    // Bounds
    always_comb begin
        w_c  = 18'(r_b[B_LEN-1].center);
        w_hs = 18'({6'b0, w_sq[12:1]});
        w_w  = 18'({5'b0, i_screen_width});
        w_h  = 18'({5'b0, i_screen_height});
        w_hh = 18'({6'b0, i_screen_height[12:1]});
        w_sc = w_c - w_hs;
        w_ec = w_c + w_hs;
        w_sr = w_hh - w_hs;
        w_er = w_hh + w_hs;
    end

    // Result fields; a hidden sprite keeps only frame_done
    always_comb begin
        w_res            = '0;
        w_res.frame_done = r_b[B_LEN-1].fd;
        if (r_b[B_LEN-1].vis) begin
            w_res.visible       = 1'b1;
            w_res.depth         = r_b[B_LEN-1].depth;
            w_res.center_column = r_b[B_LEN-1].center;
            w_res.size_px       = w_sq;
            w_res.start_column  = clip(w_sc, w_w);
            w_res.end_column    = clip(w_ec, w_w);
            w_res.start_row     = clip(w_sr, w_h);
            w_res.end_row       = clip(w_er, w_h);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else begin
            r_out_v <= r_b[B_LEN-1].valid;
        end
        r_res <= w_res;
    end

    assign o_valid  = r_out_v;
    assign o_result = r_res;
endmodule

// ----- bench/tb_sprite_projection_setup.sv -----
// Testbench for sprite_projection_setup: directed and random sprites under several camera setups.
// Depends on spsp_pkg and the sprite_projection_setup RTL; predicts each result in plain integer math.
module tb_sprite_projection_setup;
    import spsp_pkg::*;

    localparam int TILE = 64;
    localparam int LATENCY = 37;
    localparam int WATCHDOG_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_item       i_item;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_result_valid;
    t_result     o_result;

    sprite_projection_setup #(.TILE_UNITS(TILE)) u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_item         (i_item),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_result_valid (o_result_valid),
        .o_result       (o_result)
    );

    // Camera setup as the block holds it
    t_cfg    cam;
    t_item   sprite_queue[$];
    t_result projection_queue[$];
    int      fail_count;
    int      idle_cycles;
    int      burst_left;
    int      gap_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint clip(longint v, longint lo, longint hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic longint magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Project one sprite through the inverse camera matrix
    function automatic t_result project_sprite(t_item s);
        t_result r;
        longint dx, dy, px, py, w, h, nx, ny, det, txn, tyn;
        longint dep, half, center, size, hs;
        dx = longint'($signed(cam.dir_x));
        dy = longint'($signed(cam.dir_y));
        px = longint'($signed(cam.plane_x));
        py = longint'($signed(cam.plane_y));
        w  = longint'(cam.screen_width);
        h  = longint'(cam.screen_height);
        nx = longint'(s.sprite_tile_x) * TILE + TILE / 2 - longint'(cam.cam_pos_x);
        ny = longint'(s.sprite_tile_y) * TILE + TILE / 2 - longint'(cam.cam_pos_y);
        det = px * dy - dx * py;
        txn = dy * nx - dx * ny;
        tyn = px * ny - py * nx;
        r = '0;
        r.frame_done = s.last_sprite;
        dep = 0;
        if (det != 0 && tyn != 0 && ((tyn > 0) == (det > 0))) begin
            dep = (magnitude(tyn) <<< 22) / (TILE * magnitude(det));
            if (dep > 65535) dep = 65535;
        end
        if (dep >= 1) begin
            half   = w / 2;
            center = (half * (tyn + txn)) / tyn;
            size   = (w <<< 8) / dep;
            if (size > 8191) size = 8191;
            hs = size / 2;
            r.visible       = 1'b1;
            r.depth         = dep[15:0];
            r.center_column = 16'(clip(center, -32768, 32767));
            r.size_px       = size[12:0];
            r.start_column  = 13'(clip(center - hs, 0, w));
            r.end_column    = 13'(clip(center + hs, 0, w));
            r.start_row     = 13'(clip(h / 2 - hs, 0, h));
            r.end_row       = 13'(clip(h / 2 + hs, 0, h));
        end
        return r;
    endfunction

    // Sender: bursts of random length, random gaps between them
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_item <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end else begin
            if (start && !busy) begin
                projection_queue.push_back(project_sprite(i_item));
                void'(sprite_queue.pop_front());
            end
            if (start && busy) begin
                // hold current item
            end else if (gap_left > 0) begin
                start <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (sprite_queue.size() > 0) begin
                start <= 1'b1;
                i_item <= sprite_queue[0];
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 20);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n) begin
            if ((start && !busy) || o_result_valid) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (o_result_valid) begin
                if (projection_queue.size() == 0) begin
                    $error("unexpected result %h", o_result);
                    fail_count <= fail_count + 1;
                end else begin
                    exp_r = projection_queue.pop_front();
                    if (o_result !== exp_r) begin
                        fail_count <= fail_count + 1;
                        if (o_result.visible !== exp_r.visible)
                            $error("visible exp %0d got %0d", exp_r.visible, o_result.visible);
                        if (o_result.depth !== exp_r.depth)
                            $error("depth exp %0d got %0d", exp_r.depth, o_result.depth);
                        if (o_result.center_column !== exp_r.center_column)
                            $error("center_column exp %0d got %0d",
                                   exp_r.center_column, o_result.center_column);
                        if (o_result.size_px !== exp_r.size_px)
                            $error("size_px exp %0d got %0d",
                                   exp_r.size_px, o_result.size_px);
                        if (o_result.start_column !== exp_r.start_column)
                            $error("start_column exp %0d got %0d",
                                   exp_r.start_column, o_result.start_column);
                        if (o_result.end_column !== exp_r.end_column)
                            $error("end_column exp %0d got %0d",
                                   exp_r.end_column, o_result.end_column);
                        if (o_result.start_row !== exp_r.start_row)
                            $error("start_row exp %0d got %0d", exp_r.start_row, o_result.start_row);
                        if (o_result.end_row !== exp_r.end_row)
                            $error("end_row exp %0d got %0d", exp_r.end_row, o_result.end_row);
                        if (o_result.frame_done !== exp_r.frame_done)
                            $error("frame_done exp %0d got %0d",
                                   exp_r.frame_done, o_result.frame_done);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item or result
    always @(posedge i_clk) begin
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_CAM_POS_X: cam.cam_pos_x = val;
            REG_CAM_POS_Y: cam.cam_pos_y = val;
            REG_DIR_X:     cam.dir_x = val;
            REG_DIR_Y:     cam.dir_y = val;
            REG_PLANE_X:   cam.plane_x = val;
            REG_PLANE_Y:   cam.plane_y = val;
            REG_SCREEN_W:  cam.screen_width = val[12:0];
            REG_SCREEN_H:  cam.screen_height = val[12:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (sprite_queue.size() != 0 || start || projection_queue.size() != 0)
            @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic add_sprite(input logic [7:0] tx, input logic [7:0] ty, input logic last);
        t_item s;
        s.sprite_tile_x = tx;
        s.sprite_tile_y = ty;
        s.last_sprite = last;
        sprite_queue.push_back(s);
    endtask

    // Mostly sprites near the player, so they land on screen
    task automatic add_random_sprites(input int count);
        int cx, cy;
        for (int k = 0; k < count; k++) begin
            cx = cam.cam_pos_x / TILE;
            cy = cam.cam_pos_y / TILE;
            if ($urandom_range(0, 3) == 0)
                add_sprite(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           1'($urandom_range(0, 1)));
            else
                add_sprite(8'(clip(cx + int'($urandom_range(0, 40)) - 20, 0, 255)),
                           8'(clip(cy + int'($urandom_range(0, 40)) - 20, 0, 255)),
                           ($urandom_range(0, 7) == 0));
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = REG_CAM_POS_X;
        i_cfg_data = '0;
        fail_count = 0;
        idle_cycles = 0;
        cam = '{16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 16'd10813, 13'd640, 13'd480};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset camera, field extremes, behind, far, on axis
        write_reg(REG_CAM_POS_X, 16'd640);
        write_reg(REG_CAM_POS_Y, 16'd640);
        add_sprite(8'd0, 8'd0, 1'b0);
        add_sprite(8'd255, 8'd255, 1'b1);
        add_sprite(8'd255, 8'd0, 1'b0);
        add_sprite(8'd0, 8'd255, 1'b1);
        add_sprite(8'd10, 8'd10, 1'b0);     // sprite in the camera's tile
        add_sprite(8'd11, 8'd10, 1'b0);     // just ahead, huge size
        add_sprite(8'd9, 8'd10, 1'b0);      // behind
        add_sprite(8'd11, 8'd30, 1'b0);     // center far off screen
        add_sprite(8'd200, 8'd10, 1'b1);
        add_sprite(8'hAA, 8'h55, 1'b0);
        add_sprite(8'h55, 8'hAA, 1'b1);
        drain();

        // Zero determinant
        write_reg(REG_PLANE_Y, 16'd0);
        add_sprite(8'd20, 8'd10, 1'b1);
        drain();

        // Extremes: huge depth with tiny determinant, zero screen, max screen
        write_reg(REG_CAM_POS_X, 16'd0);
        write_reg(REG_CAM_POS_Y, 16'd0);
        write_reg(REG_DIR_X, 16'h7FFF);
        write_reg(REG_PLANE_Y, 16'd1);
        write_reg(REG_SCREEN_W, 16'd0);
        write_reg(REG_SCREEN_H, 16'd0);
        add_sprite(8'd255, 8'd0, 1'b0);
        add_sprite(8'd0, 8'd0, 1'b1);
        drain();
        write_reg(REG_SCREEN_W, 16'd4096);
        write_reg(REG_SCREEN_H, 16'd4096);
        write_reg(REG_DIR_X, 16'h8000);
        write_reg(REG_DIR_Y, 16'h7FFF);
        write_reg(REG_PLANE_X, 16'h8000);
        write_reg(REG_PLANE_Y, 16'h7FFF);
        write_reg(REG_CAM_POS_X, 16'hFFFF);
        write_reg(REG_CAM_POS_Y, 16'hFFFF);
        add_sprite(8'd0, 8'd255, 1'b0);
        add_sprite(8'd255, 8'd0, 1'b1);
        add_sprite(8'd250, 8'd250, 1'b0);
        drain();

        // Random phases, each with a new camera
        for (int ph = 0; ph < 7; ph++) begin
            write_reg(REG_CAM_POS_X, 16'($urandom_range(0, 65535)));
            write_reg(REG_CAM_POS_Y, 16'($urandom_range(0, 65535)));
            if (ph < 5) begin
                write_reg(REG_DIR_X, 16'($urandom_range(0, 65535)));
                write_reg(REG_DIR_Y, 16'($urandom_range(0, 65535)));
                write_reg(REG_PLANE_X, 16'($urandom_range(0, 65535)));
                write_reg(REG_PLANE_Y, 16'($urandom_range(0, 65535)));
            end else begin
                write_reg(REG_DIR_X, 16'd16384);
                write_reg(REG_DIR_Y, 16'd0);
                write_reg(REG_PLANE_X, 16'd0);
                write_reg(REG_PLANE_Y, 16'd10813);
            end
            write_reg(REG_SCREEN_W, 16'($urandom_range(1, 4096)));
            write_reg(REG_SCREEN_H, 16'($urandom_range(1, 4096)));
            add_random_sprites(100);
            drain();
        end

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
src/spsp_pkg.sv
src/spsp_div.sv
src/spsp_front.sv
src/spsp_queue.sv
src/spsp_back.sv
src/sprite_projection_setup.sv
bench/tb_sprite_projection_setup.sv
